>>> sv/tcl_pkg.sv
// Shared types, constants and codes of the tone curve LUT engine.
`timescale 1ns / 1ps
`default_nettype none
package tcl_pkg;

	localparam int COORD_FRAC_BITS = 12;
	localparam int DEF_MAX_POINTS  = 16;
	localparam int T_BITS          = 12;
	localparam int LEVEL_SHIFT     = 3 * T_BITS + 1 + COORD_FRAC_BITS;
	localparam int XW              = 13;
	localparam int XLW             = XW + 8;
	localparam int LXW             = COORD_FRAC_BITS + 8;
	localparam logic [XW-1:0] ONE_Q = XW'(1 << COORD_FRAC_BITS);

	localparam logic MODE_POINT = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	localparam logic [1:0] KIND_PIXEL      = 2'd0;
	localparam logic [1:0] KIND_BUILT      = 2'd1;
	localparam logic [1:0] KIND_BUILT_DROP = 2'd2;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [XW-1:0] y;
	} point_t;

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_FETCH, S_INSERT, S_FRONT, S_APPEND, S_LEVEL, S_SEG,
		S_DIV, S_POLY1, S_POLY2, S_POLY3, S_QUANT, S_COMB, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		DO_NONE, DO_PIXEL, DO_STORE, DO_SORT_INIT, DO_IDENT, DO_FETCH, DO_INSERT,
		DO_FRONT, DO_APPEND, DO_END, DO_SHIFT, DO_SEGSET, DO_DIV, DO_P1, DO_P2,
		DO_P3, DO_QUANT, DO_COMB, DO_DONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_ge2;
		logic fetch_last;
		logic lvl_end;
		logic seg_adv;
		logic num_zero;
		logic div_done;
		logic lvl_last;
		logic comb_done;
	} dp_sts_t;

endpackage
`default_nettype wire

>>> sv/tcl_if.sv
// Request channels of the tone curve LUT engine: input items and results.
`timescale 1ns / 1ps
`default_nettype none
interface tcl_item_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [1:0]  channel;
	logic [12:0] point_x;
	logic [12:0] point_y;
	logic        point_last;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;

	modport source(output valid, mode, channel, point_x, point_y, point_last,
		red, green, blue, alpha, input ready);
	modport sink(input valid, mode, channel, point_x, point_y, point_last,
		red, green, blue, alpha, output ready);
endinterface

interface tcl_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	modport source(output valid, kind, out_red, out_green, out_blue, out_alpha,
		input ready);
	modport sink(input valid, kind, out_red, out_green, out_blue, out_alpha,
		output ready);
endinterface
`default_nettype wire

>>> sv/tone_curve_lut_engine.sv
// Top level of the tone curve LUT engine: sequencer, datapath and checks.
//
// Usage: one input channel (item) carries either a curve control point
// (mode 0) or an RGBA pixel (mode 1); one output channel (result) returns
// mapped pixels (kind 0) and rebuild reports (kind 1, or 2 when points
// beyond MAX_POINTS were dropped). A point without the last mark gives no
// result. Pixels are taken one per cycle while the result register is free
// or being drained, and appear in the cycle after acceptance.
// A point with the last mark starts a rebuild (fewer than two stored points
// give the identity curve): fetch and insert each stored point to sort,
// set up, add the end points, then 256 levels. A level inside the curve runs
// segment setup, the divider for t, three multiply steps and rounding; a level
// at or beyond an end point takes the end value, and each segment advance
// adds a shift step. Then the combined tables are remade. item.ready stays
// low all the while; the divider and per-level multiply chain set the rate.
// Reset: all curves and combined tables read as identity; no clearing pass.
// A stalled receiver holds the result register; the next item waits until
// the register is taken.
`timescale 1ns / 1ps
`default_nettype none
module tone_curve_lut_engine import tcl_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic         clk,
	input  logic         arst_n,
	tcl_item_if.sink     item,
	tcl_result_if.source result
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	tcl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_mode  (item.mode),
		.in_last  (item.point_last),
		.in_ready (item.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcl_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.channel  (item.channel),
		.point_x  (item.point_x),
		.point_y  (item.point_y),
		.red      (item.red),
		.green    (item.green),
		.blue     (item.blue),
		.alpha    (item.alpha),
		.kind     (result.kind),
		.out_red  (result.out_red),
		.out_green(result.out_green),
		.out_blue (result.out_blue),
		.out_alpha(result.out_alpha)
	);

	// no rebuild step runs while input is open
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> (cmd.op == DO_NONE || cmd.op == DO_PIXEL || cmd.op == DO_STORE))
		else $error("input open during rebuild");

	// end of rebuild presents a report
	a_done_report: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DO_DONE |=> result.valid && result.kind != KIND_PIXEL)
		else $error("rebuild report missing");

	// reports carry zero colour fields
	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind != KIND_PIXEL |->
			result.out_red == 8'd0 && result.out_green == 8'd0 &&
			result.out_blue == 8'd0 && result.out_alpha == 8'd0)
		else $error("report with colour data");
endmodule
`default_nettype wire

>>> sv/tcl_div.sv
// Restoring divider giving the rounded segment parameter t, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module tcl_div import tcl_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           step,
	input  logic [XLW-1:0] num,
	input  logic [XLW-1:0] den,
	output logic [T_BITS:0] quo,
	output logic           done
);
	localparam int QW = T_BITS + 1;
	localparam int NW = XLW + T_BITS + 1;
	localparam int CW = $clog2(QW + 1);

	logic [NW-1:0]  dividend;
	logic [XLW:0]   rem_q;
	logic [QW-1:0]  low_q;
	logic [QW-1:0]  quo_q;
	logic [XLW-1:0] den_q;
	logic [CW-1:0]  cnt_q;
	logic [XLW+1:0] trial;

	// numerator scaled by one t unit plus half the divisor for rounding
	assign dividend = {1'b0, num, T_BITS'(0)} + NW'(den >> 1);
	assign trial    = {rem_q, low_q[QW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(QW);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (XLW+1)'(dividend >> QW);
			low_q <= dividend[QW-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (step && cnt_q != '0) begin
			low_q <= {low_q[QW-2:0], 1'b0};
			if (trial >= (XLW+2)'(den_q)) begin
				rem_q <= (XLW+1)'(trial - (XLW+2)'(den_q));
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial[XLW:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	assign quo  = quo_q;
	assign done = (cnt_q == '0);
endmodule
`default_nettype wire

>>> sv/tcl_ctrl.sv
// Sequencer of the tone curve LUT engine: handshakes and rebuild steps.
`timescale 1ns / 1ps
`default_nettype none
module tcl_ctrl import tcl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_mode,
	input  logic    in_last,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	state_t st_q, st_nxt;
	logic   out_full_q;
	logic   out_free;

	assign out_free  = !out_full_q || out_ready;
	assign out_valid = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			out_full_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (cmd.op == DO_PIXEL || cmd.op == DO_DONE) begin
				out_full_q <= 1'b1;
			end else if (out_ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	// next state and datapath command
	always_comb begin
		st_nxt   = st_q;
		cmd.op   = DO_NONE;
		in_ready = 1'b0;
		case (st_q)
			S_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					if (in_mode == MODE_PIXEL) begin
						cmd.op = DO_PIXEL;
					end else begin
						cmd.op = DO_STORE;
						if (in_last) st_nxt = S_START;
					end
				end
			end
			S_START: begin
				if (sts.cnt_ge2) begin
					cmd.op = DO_SORT_INIT;
					st_nxt = S_FETCH;
				end else begin
					cmd.op = DO_IDENT;
					st_nxt = S_COMB;
				end
			end
			S_FETCH: begin
				cmd.op = DO_FETCH;
				st_nxt = S_INSERT;
			end
			S_INSERT: begin
				cmd.op = DO_INSERT;
				st_nxt = sts.fetch_last ? S_FRONT : S_FETCH;
			end
			S_FRONT: begin
				cmd.op = DO_FRONT;
				st_nxt = S_APPEND;
			end
			S_APPEND: begin
				cmd.op = DO_APPEND;
				st_nxt = S_LEVEL;
			end
			S_LEVEL: begin
				if (sts.lvl_end) begin
					cmd.op = DO_END;
					st_nxt = S_QUANT;
				end else begin
					st_nxt = S_SEG;
				end
			end
			S_SEG: begin
				if (sts.seg_adv) begin
					cmd.op = DO_SHIFT;
				end else begin
					cmd.op = DO_SEGSET;
					st_nxt = sts.num_zero ? S_POLY1 : S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					st_nxt = S_POLY1;
				end else begin
					cmd.op = DO_DIV;
				end
			end
			S_POLY1: begin
				cmd.op = DO_P1;
				st_nxt = S_POLY2;
			end
			S_POLY2: begin
				cmd.op = DO_P2;
				st_nxt = S_POLY3;
			end
			S_POLY3: begin
				cmd.op = DO_P3;
				st_nxt = S_QUANT;
			end
			S_QUANT: begin
				cmd.op = DO_QUANT;
				st_nxt = sts.lvl_last ? S_COMB : S_LEVEL;
			end
			S_COMB: begin
				cmd.op = DO_COMB;
				if (sts.comb_done) st_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.op = DO_DONE;
					st_nxt = S_IDLE;
				end
			end
			default: begin
				st_nxt = S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

>>> sv/tcl_dp.sv
// Datapath: point store, insertion sorter, spline evaluator and LUT memories.
`timescale 1ns / 1ps
`default_nettype none
module tcl_dp import tcl_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [1:0]  channel,
	input  logic [12:0] point_x,
	input  logic [12:0] point_y,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	output logic [1:0]  kind,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha
);
	localparam int NC    = MAX_POINTS + 2;
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int NW    = $clog2(NC + 1);
	localparam int PMD   = 4 * MAX_POINTS;
	localparam int AW    = $clog2(PMD);
	localparam int SW    = 18;
	localparam int MW    = 43;
	localparam int TW    = T_BITS + 2;
	localparam int ACC_W = MW + TW;
	localparam int Y1_SH = 3 * T_BITS + 1;

	function automatic logic [XLW-1:0] x255(input logic [XW-1:0] x);
		x255 = {x, 8'b0} - XLW'(x);
	endfunction

	// ---- point store ----
	logic [CW-1:0] cnt_q [4];
	logic [3:0]    loading_q;
	logic [3:0]    ovf_q;
	logic [1:0]    cur_q;
	logic [CW-1:0] build_n_q;
	logic [CW-1:0] cnt_eff;
	logic [XW-1:0] px, py;
	logic          pm_we;
	logic [AW-1:0] pm_wa, pm_ra;
	point_t        pmem [PMD];
	point_t        pm_rd_q;

	assign cnt_eff = loading_q[channel] ? cnt_q[channel] : '0;
	assign px      = (point_x > ONE_Q) ? ONE_Q : point_x;
	assign py      = (point_y > ONE_Q) ? ONE_Q : point_y;
	assign pm_we   = (cmd.op == DO_STORE) && (int'(cnt_eff) < MAX_POINTS);
	assign pm_wa   = AW'(int'(channel) * MAX_POINTS + int'(cnt_eff));

	// take a point, open the curve on its first point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++) cnt_q[c] <= CW'(2);
			loading_q <= '0;
			ovf_q     <= '0;
			cur_q     <= '0;
			build_n_q <= '0;
		end else if (cmd.op == DO_STORE) begin
			cur_q              <= channel;
			loading_q[channel] <= 1'b1;
			if (int'(cnt_eff) < MAX_POINTS) begin
				cnt_q[channel]   <= cnt_eff + CW'(1);
				build_n_q        <= cnt_eff + CW'(1);
				ovf_q[channel]   <= loading_q[channel] ? ovf_q[channel] : 1'b0;
			end else begin
				cnt_q[channel]   <= cnt_eff;
				build_n_q        <= cnt_eff;
				ovf_q[channel]   <= 1'b1;
			end
		end else if (cmd.op == DO_DONE) begin
			loading_q[cur_q] <= 1'b0;
			ovf_q[cur_q]     <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pm_we) pmem[pm_wa] <= '{x: px, y: py};
		if (cmd.op == DO_FETCH) pm_rd_q <= pmem[pm_ra];
	end

	// ---- insertion sorter and segment window ----
	point_t        cell_q [NC];
	point_t        ins [NC];
	logic [NC-1:0] sel;
	logic [NW-1:0] sort_n_q;
	logic [NW-1:0] rem_q;
	logic [CW-1:0] k_q;
	logic [XW-1:0] max_x_q;
	point_t        first_q, last_q, prev_q;
	logic          front_add, end_add;

	assign pm_ra     = AW'(int'(cur_q) * MAX_POINTS + int'(k_q));
	assign front_add = (cell_q[0].x != '0);
	assign end_add   = (max_x_q < ONE_Q);

	// stable insert: the new point lands after all points of equal x
	always_comb begin
		for (int j = 0; j < NC; j++) begin
			sel[j] = (NW'(j) >= sort_n_q) || (cell_q[j].x > pm_rd_q.x);
		end
		ins[0] = sel[0] ? pm_rd_q : cell_q[0];
		for (int j = 1; j < NC; j++) begin
			if (!sel[j]) ins[j] = cell_q[j];
			else if (!sel[j-1]) ins[j] = pm_rd_q;
			else ins[j] = cell_q[j-1];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DO_INSERT: begin
				for (int j = 0; j < NC; j++) cell_q[j] <= ins[j];
				if (sort_n_q == '0 || pm_rd_q.x >= max_x_q) begin
					max_x_q <= pm_rd_q.x;
					last_q  <= pm_rd_q;
				end
			end
			DO_FRONT: begin
				if (front_add) begin
					cell_q[0] <= '0;
					for (int j = 1; j < NC; j++) cell_q[j] <= cell_q[j-1];
					first_q <= '0;
				end else begin
					first_q <= cell_q[0];
				end
			end
			DO_APPEND: begin
				prev_q <= cell_q[0];
				if (end_add) begin
					for (int j = 0; j < NC; j++) begin
						if (NW'(j) == sort_n_q) cell_q[j] <= '{x: ONE_Q, y: ONE_Q};
					end
					last_q <= '{x: ONE_Q, y: ONE_Q};
				end
			end
			DO_SHIFT: begin
				prev_q <= cell_q[0];
				for (int j = 0; j < NC - 1; j++) cell_q[j] <= cell_q[j+1];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_n_q <= '0;
			rem_q    <= '0;
			k_q      <= '0;
		end else begin
			case (cmd.op)
				DO_SORT_INIT: begin
					sort_n_q <= '0;
					k_q      <= '0;
				end
				DO_INSERT: begin
					sort_n_q <= sort_n_q + NW'(1);
					k_q      <= k_q + CW'(1);
				end
				DO_FRONT: begin
					if (front_add) sort_n_q <= sort_n_q + NW'(1);
				end
				DO_APPEND: begin
					rem_q <= sort_n_q + NW'(end_add);
				end
				DO_SHIFT: begin
					rem_q <= rem_q - NW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// ---- level walk, segment parameter and polynomial ----
	logic [7:0]            lvl_q;
	logic [LXW-1:0]        lx;
	logic [XLW-1:0]        lx_w, num, den;
	logic                  tz_q;
	logic [T_BITS:0]       quo, t_val;
	logic                  div_done;
	logic [XW-1:0]         y0, y1, y2, y3, end_y;
	logic signed [SW-1:0]  y0s, y1s, y2s, y3s, c3, c2, dy;
	logic signed [TW-1:0]  t_s;
	logic signed [MW-1:0]  mul_a;
	logic signed [ACC_W-1:0] prod, addend, acc_q;
	logic [63:0]           acc_u, scaled, lvl_wide;
	logic [7:0]            quant;

	assign lx    = {lvl_q, COORD_FRAC_BITS'(0)};
	assign lx_w  = XLW'(lx);
	assign num   = lx_w - x255(cell_q[0].x);
	assign den   = x255(cell_q[1].x) - x255(cell_q[0].x);
	assign end_y = (lx_w <= x255(first_q.x)) ? first_q.y : last_q.y;

	tcl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.op == DO_SEGSET),
		.step  (cmd.op == DO_DIV),
		.num   (num),
		.den   (den),
		.quo   (quo),
		.done  (div_done)
	);

	assign t_val = tz_q ? '0 : quo;
	assign y0    = prev_q.y;
	assign y1    = cell_q[0].y;
	assign y2    = cell_q[1].y;
	assign y3    = (rem_q >= NW'(3)) ? cell_q[2].y : cell_q[1].y;
	assign y0s   = signed'(SW'(y0));
	assign y1s   = signed'(SW'(y1));
	assign y2s   = signed'(SW'(y2));
	assign y3s   = signed'(SW'(y3));
	assign c3    = y3s - y0s + SW'(3) * (y1s - y2s);
	assign c2    = SW'(2) * y0s - SW'(5) * y1s + SW'(4) * y2s - y3s;
	assign dy    = y2s - y0s;
	assign t_s   = signed'({1'b0, t_val});

	// Horner form: ((c3*t + c2*T)*t + dy*T^2)*t + 2*y1*T^3
	always_comb begin
		mul_a  = MW'(c3);
		addend = ACC_W'(c2) <<< T_BITS;
		case (cmd.op)
			DO_P2: begin
				mul_a  = acc_q[MW-1:0];
				addend = ACC_W'(dy) <<< (2 * T_BITS);
			end
			DO_P3: begin
				mul_a  = acc_q[MW-1:0];
				addend = ACC_W'(y1s) <<< Y1_SH;
			end
			default: begin
			end
		endcase
		prod = mul_a * t_s;
	end

	// round S*255 / 2^LEVEL_SHIFT, clamp to a byte
	always_comb begin
		acc_u    = 64'(unsigned'(acc_q));
		scaled   = (acc_u << 8) - acc_u + (64'(1) << (LEVEL_SHIFT - 1));
		lvl_wide = scaled >> LEVEL_SHIFT;
		if (acc_q <= 0) quant = 8'd0;
		else if (lvl_wide > 64'd255) quant = 8'd255;
		else quant = lvl_wide[7:0];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DO_END:    acc_q <= ACC_W'(end_y) << Y1_SH;
			DO_P1,
			DO_P2,
			DO_P3:     acc_q <= prod + addend;
			DO_SEGSET: tz_q  <= (num == '0);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else if (cmd.op == DO_APPEND) begin
			lvl_q <= '0;
		end else if (cmd.op == DO_QUANT) begin
			lvl_q <= lvl_q + 8'd1;
		end
	end

	// ---- curve tables and combined tables ----
	logic [7:0] ctab [4][256];
	logic [7:0] crd_q [4];
	logic [7:0] cmb [3][256];
	logic [7:0] prd_q [3];
	logic [3:0] tab_set_q;
	logic       comb_set_q;
	logic [8:0] comb_cnt_q;
	logic       v_s1, v_s2;
	logic [7:0] j_s1, j_s2, m_s2, m_sel;

	assign m_sel = tab_set_q[0] ? crd_q[0] : j_s1;

	always_ff @(posedge clk) begin
		if (cmd.op == DO_QUANT) ctab[cur_q][lvl_q] <= quant;
		crd_q[0] <= ctab[0][comb_cnt_q[7:0]];
		for (int b = 1; b < 4; b++) crd_q[b] <= ctab[b][m_sel];
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			for (int c = 0; c < 3; c++) begin
				cmb[c][j_s2] <= tab_set_q[c+1] ? crd_q[c+1] : m_s2;
			end
		end
		if (cmd.op == DO_PIXEL) begin
			prd_q[0] <= cmb[0][red];
			prd_q[1] <= cmb[1][green];
			prd_q[2] <= cmb[2][blue];
		end
	end

	// combine pipeline: master read, colour read, write
	always_ff @(posedge clk) begin
		j_s1 <= comb_cnt_q[7:0];
		j_s2 <= j_s1;
		m_s2 <= m_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comb_cnt_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			tab_set_q  <= '0;
			comb_set_q <= 1'b0;
		end else begin
			comb_cnt_q <= (cmd.op == DO_COMB) ? comb_cnt_q + 9'd1 : 9'd0;
			v_s1       <= (cmd.op == DO_COMB) && !comb_cnt_q[8];
			v_s2       <= v_s1 && (cmd.op == DO_COMB);
			if (cmd.op == DO_COMB) comb_set_q <= 1'b1;
			if (cmd.op == DO_IDENT) tab_set_q[cur_q] <= 1'b0;
			if (cmd.op == DO_QUANT && lvl_q == 8'd255) tab_set_q[cur_q] <= 1'b1;
		end
	end

	// ---- result register ----
	logic       is_pix_q, sel_q;
	logic [1:0] kind_q;
	logic [7:0] raw_q [3];
	logic [7:0] alpha_q;

	always_ff @(posedge clk) begin
		if (cmd.op == DO_PIXEL) begin
			is_pix_q <= 1'b1;
			sel_q    <= comb_set_q;
			kind_q   <= KIND_PIXEL;
			raw_q[0] <= red;
			raw_q[1] <= green;
			raw_q[2] <= blue;
			alpha_q  <= alpha;
		end else if (cmd.op == DO_DONE) begin
			is_pix_q <= 1'b0;
			kind_q   <= ovf_q[cur_q] ? KIND_BUILT_DROP : KIND_BUILT;
		end
	end

	assign kind      = kind_q;
	assign out_red   = !is_pix_q ? 8'd0 : (sel_q ? prd_q[0] : raw_q[0]);
	assign out_green = !is_pix_q ? 8'd0 : (sel_q ? prd_q[1] : raw_q[1]);
	assign out_blue  = !is_pix_q ? 8'd0 : (sel_q ? prd_q[2] : raw_q[2]);
	assign out_alpha = !is_pix_q ? 8'd0 : alpha_q;

	// ---- status ----
	assign sts.cnt_ge2    = (build_n_q >= CW'(2));
	assign sts.fetch_last = (k_q + CW'(1) == build_n_q);
	assign sts.lvl_end    = (lx_w <= x255(first_q.x)) || (lx_w >= x255(last_q.x));
	assign sts.seg_adv    = (x255(cell_q[1].x) < lx_w);
	assign sts.num_zero   = (num == '0);
	assign sts.div_done   = div_done;
	assign sts.lvl_last   = (lvl_q == 8'd255);
	assign sts.comb_done  = (comb_cnt_q == 9'd257);
endmodule
`default_nettype wire

>>> bench/tone_curve_lut_engine_tb.sv
// Self-checking testbench of the tone curve LUT engine: curve loads and pixel mapping.
`timescale 1ns / 1ps
`default_nettype none
module tone_curve_lut_engine_tb import tcl_pkg::*;;

	localparam int NPT = DEF_MAX_POINTS;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] r, g, b, a;
	} mapped_t;

	// Curve mapping predictor with its own copy of the curve state
	class tone_board;
		longint pts_x[4][NPT], pts_y[4][NPT];
		int     npts[4];
		bit     loading[4], dropped[4];
		logic [7:0] curve_lut[4][256];
		logic [7:0] mix_lut[3][256];
		longint wx[NPT+2], wy[NPT+2];
		mapped_t pending[$];
		int errors;

		function new();
			errors = 0;
			for (int c = 0; c < 4; c++) begin
				pts_x[c][0] = 0; pts_y[c][0] = 0;
				pts_x[c][1] = 4096; pts_y[c][1] = 4096;
				npts[c] = 2; loading[c] = 0; dropped[c] = 0;
				for (int i = 0; i < 256; i++) curve_lut[c][i] = 8'(i);
			end
			for (int c = 0; c < 3; c++)
				for (int i = 0; i < 256; i++) mix_lut[c][i] = 8'(i);
		endfunction

		function logic [7:0] quantize(longint s);
			logic [127:0] p;
			if (s <= 0) return 0;
			p = (128'(s) * 255 + (128'(1) << (LEVEL_SHIFT - 1))) >> LEVEL_SHIFT;
			return (p > 255) ? 8'd255 : p[7:0];
		endfunction

		function logic [7:0] level_at(longint lx, int n);
			int seg, a, d;
			longint y0, y1, y2, y3, x1, x2, t, num, den, s, k;
			k = 64'd1 << T_BITS;
			if (lx <= wx[0] * 255) return quantize(wy[0] * k * k * k * 2);
			if (lx >= wx[n-1] * 255) return quantize(wy[n-1] * k * k * k * 2);
			seg = 0;
			for (int i = 0; i < n - 1; i++)
				if (lx >= wx[i] * 255 && lx <= wx[i+1] * 255) begin
					seg = i;
					break;
				end
			a = seg > 0 ? seg - 1 : 0;
			d = seg + 2 < n ? seg + 2 : n - 1;
			y0 = wy[a]; y1 = wy[seg]; y2 = wy[seg+1]; y3 = wy[d];
			x1 = wx[seg]; x2 = wx[seg+1];
			den = (x2 - x1) * 255;
			num = lx - x1 * 255;
			t = (den > 0 && num > 0) ? (num * k + den / 2) / den : 0;
			s = 2 * y1 * k * k * k + (y2 - y0) * t * k * k
				+ (2 * y0 - 5 * y1 + 4 * y2 - y3) * t * t * k
				+ (-y0 + 3 * y1 - 3 * y2 + y3) * t * t * t;
			return quantize(s);
		endfunction

		// Rebuild one curve: stable sort, add endpoints, evaluate 256 levels
		function void rebuild(int c);
			int n, m, j;
			longint px, py;
			n = npts[c];
			if (n < 2) begin
				for (int i = 0; i < 256; i++) curve_lut[c][i] = 8'(i);
				return;
			end
			for (int i = 0; i < n; i++) begin
				px = pts_x[c][i]; py = pts_y[c][i];
				j = i;
				while (j > 0 && wx[j] > px) begin
					wx[j+1] = wx[j]; wy[j+1] = wy[j];
					j--;
				end
				wx[j+1] = px; wy[j+1] = py;
			end
			// sorted points sit in wx[1..n]
			m = 0;
			if (wx[1] > 0) begin
				wx[0] = 0; wy[0] = 0; m = n + 1;
			end else begin
				for (int i = 0; i < n; i++) begin
					wx[i] = wx[i+1]; wy[i] = wy[i+1];
				end
				m = n;
			end
			if (wx[m-1] < 4096) begin
				wx[m] = 4096; wy[m] = 4096; m++;
			end
			for (int i = 0; i < 256; i++) curve_lut[c][i] = level_at(longint'(i) * 4096, m);
		endfunction

		function void note_request(logic mode, logic [1:0] ch, logic [12:0] x, logic [12:0] y,
			logic last, logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] al);
			mapped_t e;
			longint px, py;
			int c;
			c = ch;
			if (mode == MODE_PIXEL) begin
				e.kind = KIND_PIXEL;
				e.r = mix_lut[0][r]; e.g = mix_lut[1][g]; e.b = mix_lut[2][b]; e.a = al;
				pending.push_back(e);
				return;
			end
			px = x > 4096 ? 4096 : x;
			py = y > 4096 ? 4096 : y;
			if (!loading[c]) begin
				loading[c] = 1; npts[c] = 0; dropped[c] = 0;
			end
			if (npts[c] < NPT) begin
				pts_x[c][npts[c]] = px; pts_y[c][npts[c]] = py; npts[c]++;
			end else
				dropped[c] = 1;
			if (!last) return;
			rebuild(c);
			for (int k = 0; k < 3; k++)
				for (int i = 0; i < 256; i++) mix_lut[k][i] = curve_lut[k+1][curve_lut[0][i]];
			e.kind = dropped[c] ? KIND_BUILT_DROP : KIND_BUILT;
			e.r = 0; e.g = 0; e.b = 0; e.a = 0;
			pending.push_back(e);
			loading[c] = 0; dropped[c] = 0;
		endfunction

		function void check_result(logic [1:0] kind, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] al);
			mapped_t e;
			if (pending.size() == 0) begin
				$error("unexpected result kind %0d", kind);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (kind !== e.kind) begin
				$error("kind expected %0d actual %0d", e.kind, kind); errors++;
			end
			if (r !== e.r) begin
				$error("out_red expected %0d actual %0d", e.r, r); errors++;
			end
			if (g !== e.g) begin
				$error("out_green expected %0d actual %0d", e.g, g); errors++;
			end
			if (b !== e.b) begin
				$error("out_blue expected %0d actual %0d", e.b, b); errors++;
			end
			if (al !== e.a) begin
				$error("out_alpha expected %0d actual %0d", e.a, al); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	bit   sending = 0;
	bit   hold_off = 0;
	tcl_item_if   item();
	tcl_result_if result();
	tone_board    board = new();

	tone_curve_lut_engine dut (.clk(clk), .arst_n(arst_n), .item(item), .result(result));

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		item.valid = 0; item.mode = 0; item.channel = 0; item.point_x = 0;
		item.point_y = 0; item.point_last = 0; item.red = 0; item.green = 0;
		item.blue = 0; item.alpha = 0; result.ready = 0;
	end

	// Note accepted requests and check results at each edge
	always @(posedge clk) begin
		if (arst_n && item.valid && item.ready)
			board.note_request(item.mode, item.channel, item.point_x, item.point_y,
				item.point_last, item.red, item.green, item.blue, item.alpha);
		if (arst_n && result.valid && result.ready)
			board.check_result(result.kind, result.out_red, result.out_green,
				result.out_blue, result.out_alpha);
	end

	// Stall the receiver at random, with one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n || hold_off)
			result.ready <= 0;
		else if (($urandom_range(0, 255) & 8'h30) == 0)
			result.ready <= 0;
		else
			result.ready <= ($urandom_range(0, 3) != 0) || !sending;
	end

	// Send one request, idling at random in bursts
	int burst_left = 0;
	task automatic send(logic mode, logic [1:0] ch, logic [12:0] x, logic [12:0] y,
		logic last, logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] al);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item.valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item.valid <= 1; item.mode <= mode; item.channel <= ch;
		item.point_x <= x; item.point_y <= y; item.point_last <= last;
		item.red <= r; item.green <= g; item.blue <= b; item.alpha <= al;
		do @(posedge clk); while (!item.ready);
	endtask

	task automatic pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] al);
		send(MODE_PIXEL, 2'($urandom), 13'($urandom), 13'($urandom), 1'($urandom),
			r, g, b, al);
	endtask

	task automatic point(logic [1:0] ch, logic [12:0] x, logic [12:0] y, logic last);
		send(MODE_POINT, ch, x, y, last, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	function automatic logic [12:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 13'(0);
			1: return 13'(4096);
			2: return 13'($urandom_range(4097, 8191));
			default: return 13'($urandom_range(0, 4096));
		endcase
	endfunction

	// Load a well-formed curve of random points
	task automatic load_curve(logic [1:0] ch, int n);
		for (int i = 0; i < n; i++) point(ch, rand_coord(), rand_coord(), i == n - 1);
	endtask

	initial begin
		int kind_sel;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		sending = 1;

		// Directed: identity pixels, extremes, each curve and the special cases
		pixel(0, 0, 0, 0);
		pixel(255, 255, 255, 255);
		pixel(8'hAA, 8'h55, 8'h0F, 8'hF0);
		point(1, 13'h1FFF, 13'h1FFF, 1);        // lone point: identity
		point(0, 1024, 3072, 0);                 // master with endpoints added
		point(0, 3072, 1024, 1);
		pixel(128, 64, 200, 7);
		point(2, 0, 4096, 0);                    // inverted green, endpoints present
		point(2, 4096, 0, 1);
		point(3, 2048, 1000, 0);                 // equal x keeps load order
		point(3, 2048, 3000, 0);
		pixel(1, 2, 3, 4);                       // pixel while loading blue
		point(3, 0, 0, 1);
		for (int i = 0; i < 18; i++)             // too many points dropped
			point(1, 13'($urandom_range(0, 4096)), 13'($urandom_range(0, 4096)), i == 17);
		pixel(255, 0, 127, 128);

		// Random: mostly well-formed curves and pixels, some loose points
		hold_off = 0;
		for (int n = 0; n < 800; n++) begin
			if (n == 300) begin
				hold_off = 1;
				fork
					begin
						repeat (400) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			kind_sel = $urandom_range(0, 99);
			if (kind_sel < 4)
				load_curve(2'($urandom), ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
					: $urandom_range(1, 6));
			else if (kind_sel < 8)
				point(2'($urandom), rand_coord(), rand_coord(), 0);
			else
				pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
		item.valid <= 0;
		sending = 0;

		// Drain
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("tone_curve_lut_engine: match");
		else
			$display("tone_curve_lut_engine: mismatch");
		$finish;
	end

	initial begin
		#60ms;
		$display("tone_curve_lut_engine: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
sv/tcl_pkg.sv
sv/tcl_if.sv
sv/tcl_div.sv
sv/tcl_ctrl.sv
sv/tcl_dp.sv
sv/tone_curve_lut_engine.sv
bench/tone_curve_lut_engine_tb.sv
